FILE: hdl/brbp_pkg.sv
`timescale 1ns / 1ps
package brbp_pkg;

   localparam int DEPTH       = 1024;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int COUNT_W     = 11;
   localparam int BYTE_W      = 8;
   localparam int OFFSET_W    = 10;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_STORE  = 2'd1,
      CMD_LOAD   = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_ROOM = 2'd1,
      STATUS_NO_DATA = 2'd2
   } status_type;

   typedef struct packed {
      logic                 wr_en;
      logic                 rd_en;
      logic [ADDR_W-1:0]    addr;
      logic [BYTE_W-1:0]    wdata;
      status_type           status;
      logic [COUNT_W-1:0]   fill;
      logic                 last;
   } op_type;

endpackage

FILE: hdl/byte_ring_buffer_with_peek.sv
// an accepted item is registered in the queue, then in the pending response registers, then offered
// throughput: one item per cycle when not stalled; a successful item makes one access to the single-port byte store
// a two-entry queue parts classification from store access; req_stall rises when it is full
// reset clears head index, fill count and queue, and sets the ring length to the full depth
// store contents stay undefined until written; there is no clearing pass
`timescale 1ns / 1ps
module byte_ring_buffer_with_peek
   import brbp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [COUNT_W-1:0]  csr_write_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  logic [BYTE_W-1:0]   req_write_byte,
   input  logic [OFFSET_W-1:0] req_position_offset,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BYTE_W-1:0]   rsp_read_byte,
   output logic [1:0]          rsp_status,
   output logic [COUNT_W-1:0]  rsp_fill_level,
   output logic                rsp_last_out
);

   logic   push;
   op_type push_op;
   logic   q_full;
   logic   pop;
   logic   q_valid;
   op_type q_op;

   brbp_front u_front (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_write_byte      (req_write_byte),
      .req_position_offset (req_position_offset),
      .req_last            (req_last),
      .q_full              (q_full),
      .push                (push),
      .push_op             (push_op)
   );

   brbp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (q_full),
      .pop     (pop),
      .q_valid (q_valid),
      .q_op    (q_op)
   );

   brbp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_op           (q_op),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_status     (rsp_status),
      .rsp_fill_level (rsp_fill_level),
      .rsp_last_out   (rsp_last_out)
   );

endmodule

FILE: hdl/brbp_ram.sv
`timescale 1ns / 1ps
module brbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/brbp_front.sv
`timescale 1ns / 1ps
module brbp_front
   import brbp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [COUNT_W-1:0]  csr_write_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  logic [BYTE_W-1:0]   req_write_byte,
   input  logic [OFFSET_W-1:0] req_position_offset,
   input  logic                req_last,
   input  logic                q_full,
   output logic                push,
   output op_type              push_op
);

   localparam int SUM_W = COUNT_W + 1;

   logic [COUNT_W-1:0] len_ff, len_in;
   logic [ADDR_W-1:0]  head_ff, head_in;
   logic [COUNT_W-1:0] fill_ff, fill_in;
   logic [COUNT_W-1:0] len_eff;
   logic [SUM_W-1:0]   store_off;
   logic               accept;
   cmd_type            cmd;

   function automatic logic [ADDR_W-1:0] wrap_sum(input logic [SUM_W-1:0] sum,
                                                   input logic [COUNT_W-1:0] len);
      logic [SUM_W-1:0] s;
      s = sum;
      if (s >= SUM_W'(len)) begin
         s = s - SUM_W'(len);
      end
      return s[ADDR_W-1:0];
   endfunction

   assign cmd       = cmd_type'(req_cmd);
   assign accept    = req_valid && !q_full;
   assign req_stall = q_full;
   assign push      = accept;
   assign store_off = SUM_W'(fill_ff) + SUM_W'(req_position_offset);

   always_comb begin
      if (len_ff == '0) begin
         len_eff = COUNT_W'(1);
      end else if (len_ff > COUNT_W'(DEPTH)) begin
         len_eff = COUNT_W'(DEPTH);
      end else begin
         len_eff = len_ff;
      end
   end

   always_comb begin
      head_in        = head_ff;
      fill_in        = fill_ff;
      push_op.wr_en  = 1'b0;
      push_op.rd_en  = 1'b0;
      push_op.addr   = head_ff;
      push_op.wdata  = req_write_byte;
      push_op.status = STATUS_OK;
      push_op.last   = req_last;
      case (cmd)
         CMD_ADD: begin
            if (fill_ff >= len_eff) begin
               push_op.status = STATUS_NO_ROOM;
            end else begin
               push_op.wr_en = 1'b1;
               push_op.addr  = wrap_sum(SUM_W'(head_ff) + SUM_W'(fill_ff), len_eff);
               fill_in       = fill_ff + COUNT_W'(1);
            end
         end
         CMD_STORE: begin
            if (store_off >= SUM_W'(len_eff)) begin
               push_op.status = STATUS_NO_ROOM;
            end else begin
               push_op.wr_en = 1'b1;
               push_op.addr  = wrap_sum(SUM_W'(head_ff) + store_off, len_eff);
            end
         end
         CMD_LOAD: begin
            if (COUNT_W'(req_position_offset) >= fill_ff) begin
               push_op.status = STATUS_NO_DATA;
            end else begin
               push_op.rd_en = 1'b1;
               push_op.addr  = wrap_sum(SUM_W'(head_ff) + SUM_W'(req_position_offset),
                                        len_eff);
            end
         end
         CMD_REMOVE: begin
            if (fill_ff == '0) begin
               push_op.status = STATUS_NO_DATA;
            end else begin
               push_op.rd_en = 1'b1;
               push_op.addr  = head_ff;
               head_in       = wrap_sum(SUM_W'(head_ff) + SUM_W'(1), len_eff);
               fill_in       = fill_ff - COUNT_W'(1);
            end
         end
         default: begin
            push_op.status = STATUS_OK;
         end
      endcase
      push_op.fill = fill_in;
      if (!accept) begin
         head_in = head_ff;
         fill_in = fill_ff;
      end
      len_in = len_ff;
      if (csr_write_enable) begin
         len_in  = csr_write_data;
         head_in = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= COUNT_W'(DEPTH);
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         len_ff  <= len_in;
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= len_eff)
      else $error("fill count beyond ring length");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      COUNT_W'(head_ff) < len_eff)
      else $error("head index beyond ring length");
`endif

endmodule

FILE: hdl/brbp_queue.sv
`timescale 1ns / 1ps
module brbp_queue
   import brbp_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output logic   q_valid,
   output op_type q_op
);

   op_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_op    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue count did not grow on push");
`endif

endmodule

FILE: hdl/brbp_back.sv
`timescale 1ns / 1ps
module brbp_back
   import brbp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  op_type             q_op,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BYTE_W-1:0]  rsp_read_byte,
   output logic [1:0]         rsp_status,
   output logic [COUNT_W-1:0] rsp_fill_level,
   output logic               rsp_last_out
);

   logic               pend_valid_ff, pend_valid_in;
   logic               pend_rd_ff;
   status_type         pend_status_ff;
   logic [COUNT_W-1:0] pend_fill_ff;
   logic               pend_last_ff;
   logic [BYTE_W-1:0]  ram_rdata;

   assign pop = q_valid && (!pend_valid_ff || !rsp_stall);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (pop) begin
         pend_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pend_rd_ff     <= q_op.rd_en;
         pend_status_ff <= q_op.status;
         pend_fill_ff   <= q_op.fill;
         pend_last_ff   <= q_op.last;
      end
   end

   brbp_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock (clock),
      .en    (pop && (q_op.wr_en || q_op.rd_en)),
      .we    (q_op.wr_en),
      .addr  (q_op.addr),
      .wdata (q_op.wdata),
      .rdata (ram_rdata)
   );

   assign rsp_valid      = pend_valid_ff;
   assign rsp_read_byte  = pend_rd_ff ? ram_rdata : '0;
   assign rsp_status     = pend_status_ff;
   assign rsp_fill_level = pend_fill_ff;
   assign rsp_last_out   = pend_last_ff;

`ifndef ASSERT_OFF
   a_failed_no_access: assert property (@(posedge clock) disable iff (reset)
      (pop && (q_op.status != STATUS_OK)) |-> (!q_op.wr_en && !q_op.rd_en))
      else $error("failed item touches the store");
`endif

endmodule
